// ===== rtl/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
`default_nettype none
package bra_pkg;
  localparam int MapBits   = 65536;
  localparam int WordBits  = 32;
  localparam int WordCount = MapBits / WordBits;
  localparam int AddrW     = $clog2(WordCount);
  localparam int BitW      = $clog2(WordBits);
  localparam int PosW      = $clog2(MapBits);
  localparam int LenW      = PosW + 1;

  localparam logic [2:0] REQ_ALLOC       = 3'd0;
  localparam logic [2:0] REQ_FREE        = 3'd1;
  localparam logic [2:0] REQ_CHECK_SET   = 3'd2;
  localparam logic [2:0] REQ_CHECK_CLEAR = 3'd3;
  localparam logic [2:0] REQ_MARK        = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] start_bit;
    logic [16:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] run_start;
    logic [16:0] biggest_free;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [WordBits-1:0] wdata;
  } mem_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/bra_ram.sv =====
// Single-port bitmap word memory with registered read data.
`default_nettype none
module bra_ram (
  input  wire logic                          clk,
  input  wire bra_pkg::mem_cmd_t             cmd,
  output      logic [bra_pkg::WordBits-1:0]  rdata
);
  import bra_pkg::*;
  logic [WordBits-1:0] mem [WordCount];
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    rdata <= mem[cmd.addr];
  end
endmodule
`default_nettype wire

// ===== rtl/bitmap_run_allocator.sv =====
// Top level of the bitmap run allocator: bit-serial sequencer over a word memory.
//
// Usage: one request word enters on req (valid/ready); one response word leaves on
// rsp (valid/ready) for every request. cfg_we writes bits_in_use; the user must
// write it only while idle, which the block itself does not enforce. After rst
// the block sweeps the bitmap memory to zero, one word per cycle, before it
// raises req_ready. Each request walks the bitmap bit by bit in S_BIT, with a
// registered read of the word memory (S_RD, S_LD) and a write-back (S_WB)
// whenever a word is left dirty. Allocate first reduces the hint word modulo
// the word count in S_MOD, then scans from that word bit by bit, choosing
// the next word to visit in S_AWORD and wrapping around the map; fully used
// words are skipped without a bit scan.
// The response sits in an output register; when rsp_ready is low it holds, and
// the next request is taken only after the response is delivered.
// The single memory port paces the block: each word fetch needs a read and
// each modified word a write.
`default_nettype none
module bitmap_run_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [16:0]   cfg_wdata,
  input  wire logic          req_valid,
  output      logic          req_ready,
  input  wire bra_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_ready,
  output      bra_pkg::rsp_t rsp
);
  import bra_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LD    = 4'd3;
  localparam logic [3:0] S_BIT   = 4'd4;
  localparam logic [3:0] S_WB    = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_RSP   = 4'd7;
  localparam logic [3:0] S_AWORD = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;

  localparam int ModCntW = $clog2(AddrW);

  logic [3:0]          state;
  logic [16:0]         bits_in_use;
  logic [PosW-1:0]     search_hint;
  logic                full_flag;
  logic [AddrW:0]      clr_cnt;
  req_t                cur;
  logic [16:0]         nb;
  logic [16:0]         pos;
  logic [16:0]         t;
  logic [WordBits-1:0] word;
  logic                dirty;
  logic [1:0]          st;
  logic [15:0]         rstart;
  logic [16:0]         best;
  logic [AddrW:0]      wcount;
  logic [AddrW:0]      visited;
  logic [AddrW:0]      base;
  logic                in_run;
  logic [16:0]         run_p;
  logic [16:0]         run_k;
  logic                saw_free;
  logic                setting;
  logic [16:0]         set_end;
  logic [AddrW-1:0]    wb_addr;
  logic [AddrW-1:0]    mod_num;
  logic [ModCntW-1:0]  mod_cnt;
  logic [WordBits-1:0] rdata;
  mem_cmd_t            cmd;

  bra_ram u_ram (.clk(clk), .cmd(cmd), .rdata(rdata));

  logic [AddrW-1:0] widx;
  logic [BitW-1:0]  bidx;
  logic             bitv;
  assign widx = pos[PosW-1:BitW];
  assign bidx = pos[BitW-1:0];
  assign bitv = word[bidx];
  assign nb   = (bits_in_use > 17'(MapBits)) ? 17'(MapBits) : bits_in_use;
  assign req_ready = (state == S_IDLE);

  logic [17:0] rng_end;
  assign rng_end = {2'b0, req.start_bit} + {1'b0, req.run_length};

  logic [AddrW:0] mod_shift;
  logic [AddrW:0] wsum;
  logic [AddrW:0] wnext;
  assign mod_shift = {base[AddrW-1:0], mod_num[AddrW-1]};
  assign wsum      = base + visited;
  assign wnext     = (wsum >= wcount) ? wsum - wcount : wsum;

  always_comb begin
    cmd.we    = 1'b0;
    cmd.addr  = widx;
    cmd.wdata = word;
    if (state == S_CLR) begin
      cmd.we    = 1'b1;
      cmd.addr  = clr_cnt[AddrW-1:0];
      cmd.wdata = '0;
    end else if (state == S_WB) begin
      cmd.we   = 1'b1;
      cmd.addr = wb_addr;
    end
  end

  logic [AddrW:0] wc_calc;
  assign wc_calc = (AddrW+1)'((nb + 17'(WordBits - 1)) >> BitW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_cnt     <= '0;
      bits_in_use <= 17'(MapBits);
      search_hint <= '0;
      full_flag   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        bits_in_use <= cfg_wdata;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AddrW+1)'(WordCount - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            cur      <= req;
            st       <= ST_OK;
            rstart   <= '0;
            best     <= '0;
            t        <= '0;
            dirty    <= 1'b0;
            in_run   <= 1'b0;
            run_k    <= '0;
            saw_free <= 1'b0;
            setting  <= 1'b0;
            visited  <= '0;
            wcount   <= wc_calc;
            pos      <= 17'(req.start_bit);
            state    <= S_RD;
            case (req.req_type)
              REQ_ALLOC: begin
                if (req.run_length == '0 || req.run_length > nb || full_flag
                    || wc_calc == '0) begin
                  st    <= ST_FAIL;
                  state <= S_DONE;
                end else begin
                  base    <= '0;
                  mod_num <= search_hint[PosW-1:BitW];
                  mod_cnt <= '0;
                  state   <= S_MOD;
                end
              end
              REQ_FREE: begin
                full_flag <= 1'b0;
                if (rng_end > {1'b0, nb}) begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end else begin
                  search_hint <= req.start_bit;
                  if (req.run_length == '0) state <= S_DONE;
                end
              end
              REQ_CHECK_SET, REQ_CHECK_CLEAR: begin
                if (rng_end > {1'b0, nb}) begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end else if (req.run_length == '0) begin
                  state <= S_DONE;
                end
              end
              REQ_MARK: begin
                if (req.run_length == '0) begin
                  state <= S_DONE;
                end else if ({1'b0, req.start_bit} >= nb) begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end
              end
              default: begin
                st    <= ST_FAIL;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MOD: begin
          base    <= (mod_shift >= wcount) ? mod_shift - wcount : mod_shift;
          mod_num <= {mod_num[AddrW-2:0], 1'b0};
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == ModCntW'(AddrW - 1)) state <= S_AWORD;
        end
        S_AWORD: begin
          // set scan position to the start of the next word to visit, or fail once every word is visited
          if (visited >= wcount) begin
            if (!saw_free) full_flag <= 1'b1;
            st    <= ST_FAIL;
            state <= S_DONE;
          end else begin
            pos   <= {wnext, {BitW{1'b0}}};
            state <= S_RD;
          end
        end
        S_RD: begin
          wb_addr <= widx;
          state   <= S_LD;
        end
        S_LD: begin
          word  <= rdata;
          dirty <= 1'b0;
          if (cur.req_type == REQ_ALLOC && !in_run && !setting
              && rdata == {WordBits{1'b1}}) begin
            visited <= visited + 1'b1;
            state   <= S_AWORD;
          end else begin
            state <= S_BIT;
          end
        end
        S_BIT: begin
          state <= S_BIT;
          case (cur.req_type)
            REQ_FREE, REQ_MARK: begin
              if (cur.req_type == REQ_MARK && pos >= nb) begin
                st    <= ST_RANGE;
                state <= dirty ? S_WB : S_DONE;
              end else begin
                word[bidx] <= (cur.req_type == REQ_MARK);
                dirty      <= 1'b1;
                pos        <= pos + 1'b1;
                t          <= t + 1'b1;
                if (t + 1'b1 == cur.run_length || bidx == BitW'(WordBits - 1)) begin
                  state <= S_WB;
                end
              end
            end
            REQ_CHECK_SET, REQ_CHECK_CLEAR: begin
              if (bitv != (cur.req_type == REQ_CHECK_SET)) begin
                st    <= ST_FAIL;
                state <= S_DONE;
              end else begin
                pos <= pos + 1'b1;
                t   <= t + 1'b1;
                if (t + 1'b1 == cur.run_length) state <= S_DONE;
                else if (bidx == BitW'(WordBits - 1)) state <= S_RD;
              end
            end
            default: begin
              if (setting) begin
                word[bidx] <= 1'b1;
                dirty      <= 1'b1;
                pos        <= pos + 1'b1;
                if (pos + 1'b1 == set_end || bidx == BitW'(WordBits - 1)) begin
                  state <= S_WB;
                end
              end else if (!in_run) begin
                if (bitv) begin
                  pos <= pos + 1'b1;
                  if (bidx == BitW'(WordBits - 1)) begin
                    visited <= visited + 1'b1;
                    state   <= S_AWORD;
                  end
                end else begin
                  if (pos < nb) saw_free <= 1'b1;
                  in_run <= 1'b1;
                  run_p  <= pos;
                  run_k  <= '0;
                end
              end else begin
                if (run_k < cur.run_length && pos < nb && !bitv) begin
                  run_k <= run_k + 1'b1;
                  pos   <= pos + 1'b1;
                  if (run_k + 1'b1 > best) best <= run_k + 1'b1;
                  if (bidx == BitW'(WordBits - 1) && run_k + 1'b1 < cur.run_length
                      && pos + 1'b1 < nb) begin
                    state <= S_RD;
                  end
                end else if (run_k >= cur.run_length) begin
                  // found: mark from run_p; pos is q
                  rstart  <= run_p[15:0];
                  set_end <= pos;
                  setting <= 1'b1;
                  in_run  <= 1'b0;
                  pos     <= run_p;
                  state   <= S_RD;
                end else if (pos >= nb) begin
                  in_run  <= 1'b0;
                  visited <= (visited < wcount - base) ? wcount - base : wcount;
                  state   <= S_AWORD;
                end else begin
                  // hit a used bit at pos: resume after it
                  in_run  <= 1'b0;
                  visited <= visited + (AddrW+1)'(pos[16:BitW] - run_p[16:BitW]);
                  pos     <= pos + 1'b1;
                  if (bidx == BitW'(WordBits - 1)) begin
                    visited <= visited + (AddrW+1)'(pos[16:BitW] - run_p[16:BitW]) + 1'b1;
                    state   <= S_AWORD;
                  end
                end
              end
            end
          endcase
        end
        S_WB: begin
          dirty <= 1'b0;
          if (cur.req_type == REQ_ALLOC) begin
            if (pos == set_end) begin
              // hint check: bit q must be in map and clear
              if (pos[16:BitW] < wcount) state <= S_RD;
              else state <= S_DONE;
              setting <= 1'b0;
              st      <= ST_OK;
            end else begin
              state <= S_RD;
            end
          end else if (st != ST_OK || t == cur.run_length) begin
            state <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_DONE: begin
          rsp.status       <= st;
          rsp.run_start    <= (st == ST_OK) ? rstart : '0;
          rsp.biggest_free <= (cur.req_type == REQ_ALLOC && st == ST_FAIL) ? best : '0;
          rsp_valid        <= 1'b1;
          state            <= S_RSP;
        end
        S_RSP: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // allocate hint probe: word of q loaded, not setting, set_end valid
      if (state == S_LD && cur.req_type == REQ_ALLOC && !setting && !in_run
          && st == ST_OK && rstart == run_p[15:0] && pos == set_end
          && set_end != '0 && run_k == cur.run_length) begin
        if (!rdata[bidx]) search_hint <= pos[PosW-1:0];
        state <= S_DONE;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bra_checker.sv =====
// Port-level assertions for the bitmap run allocator, bound to the top level.
`default_nettype none
module bra_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire bra_pkg::rsp_t rsp
);
  import bra_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while response pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped under stall");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid)
    else $error("request withdrawn before accept");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != 2'd3) else $error("bad status");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.run_start == '0)
    else $error("run_start set on failure");
endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
`default_nettype wire
